// File: rtl/kscd_pkg.sv
// ----------------------------------------------------------------------------
// kscd_pkg
// Shared types, constants and helpers of the key click detector.
// ----------------------------------------------------------------------------
package kscd_pkg;

  // Width of the settle and window countdown.
  localparam int COUNT_BITS = 8;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W   = 8;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CFG_W-1:0]      cfg_t;
  typedef logic [2:0]            phase_t;

  localparam count_t CNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd1;

  localparam cfg_t SETTLE_RESET = 8'd1;
  localparam cfg_t WINDOW_RESET = 8'd50;

  // Phase codes.
  localparam phase_t PH_IDLE     = 3'd0;
  localparam phase_t PH_SETTLE1  = 3'd1;
  localparam phase_t PH_HOLD1    = 3'd2;
  localparam phase_t PH_SETTLE2  = 3'd3;
  localparam phase_t PH_WINDOW   = 3'd4;
  localparam phase_t PH_CONFIRM2 = 3'd5;
  localparam phase_t PH_HOLD2    = 3'd6;

  // LED levels, all active low.
  typedef struct packed {
    logic busy;
    logic second;
    logic first;
  } led_t;

  localparam led_t LEDS_OFF = '{busy: 1'b1, second: 1'b1, first: 1'b1};

  // Loads a register value into the counter, saturating at its top.
  function automatic count_t clip_count(input cfg_t v);
    logic [15:0] ext;
    ext = 16'(v);
    if (ext > 16'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return ext[COUNT_BITS-1:0];
  endfunction

endpackage

// File: rtl/kscd_core.sv
// ----------------------------------------------------------------------------
// kscd_core
// Click detection state machine and configuration registers.
// ----------------------------------------------------------------------------
module kscd_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kscd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  kscd_pkg::cfg_t                 cfg_wdata,
  input  logic                           step,
  input  logic                           key_level,
  output kscd_pkg::led_t                 leds_nxt
);
  import kscd_pkg::*;

  cfg_t   settle_r;
  cfg_t   window_r;
  phase_t phase_r,  phase_nxt;
  count_t count_r,  count_nxt;
  led_t   leds_r;
  logic   pressed;
  logic   settle_done;
  count_t count_dec;

  assign pressed     = ~key_level;
  assign settle_done = (count_r <= count_t'(1));
  assign count_dec   = count_r - count_t'(1);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    leds_nxt  = leds_r;
    case (phase_r)
      PH_SETTLE1: begin
        if (!settle_done) begin
          count_nxt = count_dec;
        end else if (pressed) begin
          leds_nxt.busy  = 1'b0;
          leds_nxt.first = ~leds_r.first;
          phase_nxt      = PH_HOLD1;
          count_nxt      = '0;
        end else begin
          // An unconfirmed first press still opens the second-press window.
          phase_nxt = PH_SETTLE2;
          count_nxt = clip_count(settle_r);
        end
      end
      PH_HOLD1: begin
        if (!pressed) begin
          leds_nxt.busy = 1'b1;
          phase_nxt     = PH_SETTLE2;
          count_nxt     = clip_count(settle_r);
        end
      end
      PH_SETTLE2: begin
        if (!settle_done) begin
          count_nxt = count_dec;
        end else if (pressed) begin
          phase_nxt = PH_CONFIRM2;
          count_nxt = clip_count(settle_r);
        end else if (window_r == '0) begin
          leds_nxt.busy = 1'b1;
          phase_nxt     = PH_IDLE;
          count_nxt     = '0;
        end else begin
          phase_nxt = PH_WINDOW;
          count_nxt = clip_count(window_r);
        end
      end
      PH_WINDOW: begin
        if (pressed) begin
          phase_nxt = PH_CONFIRM2;
          count_nxt = clip_count(settle_r);
        end else if (count_dec == '0) begin
          leds_nxt.busy = 1'b1;
          phase_nxt     = PH_IDLE;
          count_nxt     = '0;
        end else begin
          count_nxt = count_dec;
        end
      end
      PH_CONFIRM2: begin
        if (!settle_done) begin
          count_nxt = count_dec;
        end else if (pressed) begin
          leds_nxt.busy   = 1'b0;
          leds_nxt.second = ~leds_r.second;
          phase_nxt       = PH_HOLD2;
          count_nxt       = '0;
        end else begin
          leds_nxt.busy = 1'b1;
          phase_nxt     = PH_IDLE;
          count_nxt     = '0;
        end
      end
      PH_HOLD2: begin
        if (!pressed) begin
          leds_nxt.busy = 1'b1;
          phase_nxt     = PH_IDLE;
          count_nxt     = '0;
        end
      end
      default: begin
        // Idle and the unused code behave the same.
        if (pressed) begin
          phase_nxt = PH_SETTLE1;
          count_nxt = clip_count(settle_r);
        end else begin
          phase_nxt = PH_IDLE;
          count_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RESET;
      window_r <= WINDOW_RESET;
      phase_r  <= PH_IDLE;
      count_r  <= '0;
      leds_r   <= LEDS_OFF;
    end else begin
      if (cfg_we && cfg_idx == REG_SETTLE_TICKS) begin
        settle_r <= cfg_wdata;
      end
      if (cfg_we && cfg_idx == REG_WINDOW_TICKS) begin
        window_r <= cfg_wdata;
      end
      if (step) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        leds_r  <= leds_nxt;
      end
    end
  end

endmodule

// File: rtl/kscd_out_stage.sv
// ----------------------------------------------------------------------------
// kscd_out_stage
// Result register with valid flag; frees itself when the receiver takes it.
// ----------------------------------------------------------------------------
module kscd_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  kscd_pkg::led_t leds_in,
  input  logic           out_tready,
  output logic           out_tvalid,
  output kscd_pkg::led_t leds_out,
  output logic           space
);
  import kscd_pkg::*;

  logic valid_r;
  led_t leds_r;

  // The register can take a new result when empty or drained this cycle.
  assign space      = ~valid_r | out_tready;
  assign out_tvalid = valid_r;
  assign leds_out   = leds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      leds_r <= leds_in;
    end
  end

endmodule

// File: rtl/key_single_double_click_detector_top.sv
// ----------------------------------------------------------------------------
// key_single_double_click_detector_top
// Debounced single and double click detector driven by one key sample a tick.
// ----------------------------------------------------------------------------
// Each input transfer carries one active-low key sample taken on a
// millisecond tick. For every sample the block returns one output transfer
// with the three active-low LED levels after that tick's update.
// An accepted sample's result is registered and shows on out_tvalid and
// out_tdata in the following cycle. Throughput is one sample per cycle
// while out_tready is high, set by the single registered state machine pass.
// in_tready is high whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds back the input
// side after one waiting result, and nothing is lost or repeated.
// The configuration port writes settle_ticks (index 0) and
// double_window_ticks (index 1) at any edge where cfg_we is high; write
// only while no sample is in flight.
// Synchronous reset clears the result register, returns the detector to
// idle with all LEDs off and loads settle_ticks = 1, double_window_ticks = 50.
// ----------------------------------------------------------------------------
module key_single_double_click_detector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [kscd_pkg::TDATA_W-1:0]   in_tdata,   // [0] key_level
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [kscd_pkg::TDATA_W-1:0]   out_tdata,  // [0] first_led_level,
                                                     // [1] second_led_level,
                                                     // [2] busy_led_level
  input  logic                           cfg_we,
  input  logic [kscd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  kscd_pkg::cfg_t                 cfg_wdata
);
  import kscd_pkg::*;

  logic accept;
  logic space;
  led_t leds_nxt;
  led_t leds_out;

  assign in_tready = space;
  assign accept    = in_tvalid & space;

  kscd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step      (accept),
    .key_level (in_tdata[0]),
    .leds_nxt  (leds_nxt)
  );

  kscd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .leds_in    (leds_nxt),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .leds_out   (leds_out),
    .space      (space)
  );

  assign out_tdata = {(TDATA_W - 3)'(0), leds_out.busy, leds_out.second, leds_out.first};

endmodule

// File: rtl/kscd_checker.sv
// ----------------------------------------------------------------------------
// kscd_checker
// Port-level checks of the click detector, bound to the top level.
// ----------------------------------------------------------------------------
module kscd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [kscd_pkg::TDATA_W-1:0]   out_tdata
);
  import kscd_pkg::*;

  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted sample produces a result in the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted sample gave no result");

  // An empty result register never blocks the input side.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // The padding bits of a result are zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:3] == '0)
    else $error("result padding not zero");

endmodule

bind key_single_double_click_detector_top kscd_checker u_kscd_checker (.*);
